// ===== sv/bpd_pkg.sv =====
// shared types and constants of the byte packet deframer
package bpd_pkg;

  // frame length in bytes, header and checksum included (6 to 10)
  localparam int unsigned PacketLen = 6;
  localparam int unsigned CntW      = $clog2(PacketLen);

  localparam logic [7:0] HeaderFirst  = 8'hAA;
  localparam logic [7:0] HeaderSecond = 8'h55;

  // frame positions of the direction bytes
  localparam int unsigned ZoomPos  = 3;
  localparam int unsigned FocusPos = 4;

  localparam logic [15:0] StepAngleReset = 16'd1;

  typedef logic [7:0]      byte_t;
  typedef logic [15:0]     angle_t;
  typedef logic [CntW-1:0] cnt_t;

  // frame found by the deframer
  typedef struct packed {
    logic  valid;
    byte_t zoom_direction;
    byte_t focus_direction;
  } frame_t;

  // deframer status
  typedef struct packed {
    cnt_t  byte_count;
    byte_t running_sum;
  } status_t;

endpackage

// ===== sv/bpd_rx_if.sv =====
// request channel of received bytes
interface bpd_rx_if;
  import bpd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/bpd_res_if.sv =====
// request channel of decoded move commands
interface bpd_res_if;
  import bpd_pkg::*;

  logic   valid;
  logic   ready;
  byte_t  zoom_direction;
  byte_t  focus_direction;
  angle_t move_angle;

  modport source (output valid, output zoom_direction, output focus_direction,
                  output move_angle, input ready);
  modport sink (input valid, input zoom_direction, input focus_direction,
                input move_angle, output ready);
endinterface

// ===== sv/bpd_framer.sv =====
// frame hunt: byte position, running checksum and direction holding registers
module bpd_framer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  bpd_pkg::byte_t   rx_byte_i,
  output bpd_pkg::frame_t  frame_o,
  output bpd_pkg::status_t status_o
);
  import bpd_pkg::*;

  cnt_t  count_q, count_d;
  byte_t sum_q, sum_d;
  byte_t zoom_q, zoom_d;
  byte_t focus_q, focus_d;
  logic  hit;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    zoom_d  = zoom_q;
    focus_d = focus_q;
    hit     = 1'b0;
    if (accept_i) begin
      if (count_q == '0) begin
        // wrong first header byte is simply skipped
        if (rx_byte_i == HeaderFirst) begin
          count_d = cnt_t'(1);
          sum_d   = rx_byte_i;
        end
      end else if (count_q == cnt_t'(1)) begin
        if (rx_byte_i != HeaderSecond) begin
          count_d = '0;
          sum_d   = '0;
        end else begin
          count_d = cnt_t'(2);
          sum_d   = sum_q + rx_byte_i;
        end
      end else if (count_q >= cnt_t'(PacketLen - 1)) begin
        // checksum byte ends the frame either way
        count_d = '0;
        sum_d   = '0;
        hit     = (sum_q == rx_byte_i);
      end else begin
        if (count_q == cnt_t'(ZoomPos)) begin
          zoom_d = rx_byte_i;
        end
        if (count_q == cnt_t'(FocusPos)) begin
          focus_d = rx_byte_i;
        end
        sum_d   = sum_q + rx_byte_i;
        count_d = count_q + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zoom_q  <= zoom_d;
    focus_q <= focus_d;
  end

  assign frame_o.valid           = hit;
  assign frame_o.zoom_direction  = zoom_q;
  assign frame_o.focus_direction = focus_q;
  assign status_o.byte_count     = count_q;
  assign status_o.running_sum    = sum_q;
endmodule

// ===== sv/bpd_out_stage.sv =====
// result register toward the command sink
module bpd_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bpd_pkg::frame_t frame_i,
  input  bpd_pkg::angle_t step_angle_i,
  output logic            free_o,
  bpd_res_if.source       res
);
  import bpd_pkg::*;

  logic   valid_q, valid_d;
  byte_t  zoom_q;
  byte_t  focus_q;
  angle_t angle_q;

  // room for a new result when empty or when the held one leaves now
  assign free_o = !valid_q || res.ready;

  always_comb begin
    valid_d = valid_q;
    if (frame_i.valid) begin
      valid_d = 1'b1;
    end else if (res.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid) begin
      zoom_q  <= frame_i.zoom_direction;
      focus_q <= frame_i.focus_direction;
      angle_q <= step_angle_i;
    end
  end

  assign res.valid           = valid_q;
  assign res.zoom_direction  = zoom_q;
  assign res.focus_direction = focus_q;
  assign res.move_angle      = angle_q;
endmodule

// ===== sv/byte_packet_deframer_checksum_top.sv =====
// top level of the byte packet deframer with additive checksum
// takes one received serial byte per request and hunts for a frame of
// PacketLen bytes: 0xAA, 0x55, payload, and a last byte that must equal the
// 8-bit wrapping sum of all earlier frame bytes. bytes 3 and 4 are the zoom
// and focus direction. a good frame yields one command request carrying both
// directions and the step angle register; a wrong header byte or a bad
// checksum drops the frame with no output and the hunt starts over with the
// next byte (a rejected second header byte is not retried as a first one).
// one byte is taken every cycle: the per-byte work is a position counter, an
// 8-bit add and a compare ahead of a single result register. the result
// shows up the cycle after the checksum byte is taken, and input stalls only
// while that register holds a command the sink has not taken.
module byte_packet_deframer_checksum_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_angle_we_i,
  input  bpd_pkg::angle_t step_angle_i,
  bpd_rx_if.sink          rx_i,
  bpd_res_if.source       res_o
);
  import bpd_pkg::*;

  angle_t  step_angle_q;
  logic    free;
  logic    accept;
  frame_t  frame;
  status_t status;

  // step angle register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_angle_q <= StepAngleReset;
    end else if (step_angle_we_i) begin
      step_angle_q <= step_angle_i;
    end
  end

  // every byte may yield a command, so take one only with room downstream
  assign rx_i.ready = free;
  assign accept     = rx_i.valid && free;

  bpd_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_i.rx_byte),
    .frame_o   (frame),
    .status_o  (status)
  );

  bpd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frame),
    .step_angle_i (step_angle_q),
    .free_o       (free),
    .res          (res_o)
  );

  // position never runs past the checksum byte
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.byte_count <= cnt_t'(PacketLen - 1))
    else $error("byte count beyond frame length");

  // a new command only follows a taken byte
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(rx_i.valid && rx_i.ready))
    else $error("command without a taken byte");

  // a good frame always restarts the hunt
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.valid |=> (status.byte_count == '0 && status.running_sum == '0))
    else $error("hunt not restarted after frame");

  // a stalled command blocks input
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !rx_i.ready)
    else $error("byte taken while command stalled");
endmodule
